>>> rtl/core/hrs_pkg.sv
// ----------------------------------------------------------------------------
// hrs_pkg - shared types and constants of the heater relay switch sequencer
// Phase codes, drive and configuration structs, register indexes and the
// register reset values.
// ----------------------------------------------------------------------------
package hrs_pkg;

   localparam int TICK_W  = 16;
   localparam int BEEPS_W = 2;
   localparam int CSR_IDX_W = 3;

   localparam logic [TICK_W-1:0] TIMER_MAX = '1;

   // register reset values
   localparam logic [TICK_W-1:0] LEAD_RESET  = 16'd150;
   localparam logic [TICK_W-1:0] HOLD_RESET  = 16'd200;
   localparam logic [TICK_W-1:0] BEEP_RESET  = 16'd100;
   localparam logic [TICK_W-1:0] DARK_RESET  = 16'd15000;
   localparam logic [TICK_W-1:0] LIT_RESET   = 16'd1000;

   // beeps still to come after the first one of an alarm
   localparam logic [BEEPS_W-1:0] ALARM_BEEPS_ON  = 2'd3;
   localparam logic [BEEPS_W-1:0] ALARM_BEEPS_OFF = 2'd2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LEAD = 3'd0,
      CSR_HOLD = 3'd1,
      CSR_BEEP = 3'd2,
      CSR_DARK = 3'd3,
      CSR_LIT  = 3'd4
   } csr_index_type;

   typedef enum logic [5:0] {
      PH_IDLE     = 6'b000001,
      PH_GAP      = 6'b000010,
      PH_TONE     = 6'b000100,
      PH_ON_LEAD  = 6'b001000,
      PH_OFF_LEAD = 6'b010000,
      PH_HOLD     = 6'b100000
   } phase_type;

   typedef struct packed {
      logic relay;
      logic triac;
      logic led;
      logic beeper;
   } drive_type;

   typedef struct packed {
      logic [TICK_W-1:0] lead_ticks;
      logic [TICK_W-1:0] hold_ticks;
      logic [TICK_W-1:0] beep_ticks;
      logic [TICK_W-1:0] dark_ticks;
      logic [TICK_W-1:0] lit_ticks;
   } cfg_type;

endpackage

>>> rtl/core/hrs_if.sv
// ----------------------------------------------------------------------------
// hrs_req_if / hrs_rsp_if - request and result channels
// Valid/ready channels carrying the tick sample and the four drive levels.
// ----------------------------------------------------------------------------
interface hrs_req_if;
   logic valid;
   logic ready;
   logic run_switch_closed;
   logic overheat_tripped;

   modport source (output valid, output run_switch_closed, output overheat_tripped,
                   input ready);
   modport sink   (input valid, input run_switch_closed, input overheat_tripped,
                   output ready);
endinterface

interface hrs_rsp_if;
   logic valid;
   logic ready;
   logic beeper_on;
   logic status_led_on;
   logic triac_on;
   logic relay_on;

   modport source (output valid, output beeper_on, output status_led_on,
                   output triac_on, output relay_on, input ready);
   modport sink   (input valid, input beeper_on, input status_led_on,
                   input triac_on, input relay_on, output ready);
endinterface

>>> rtl/core/hrs_csr.sv
// ----------------------------------------------------------------------------
// hrs_csr - configuration registers
// Five 16-bit timing registers, written through a plain write port.
// ----------------------------------------------------------------------------
module hrs_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [hrs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [hrs_pkg::TICK_W-1:0]     csr_wdata,
   output hrs_pkg::cfg_type               cfg
);

   hrs_pkg::cfg_type cfg_ff, cfg_in;

   // decode the write
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (hrs_pkg::csr_index_type'(csr_index))
            hrs_pkg::CSR_LEAD: cfg_in.lead_ticks = csr_wdata;
            hrs_pkg::CSR_HOLD: cfg_in.hold_ticks = csr_wdata;
            hrs_pkg::CSR_BEEP: cfg_in.beep_ticks = csr_wdata;
            hrs_pkg::CSR_DARK: cfg_in.dark_ticks = csr_wdata;
            hrs_pkg::CSR_LIT:  cfg_in.lit_ticks  = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.lead_ticks <= hrs_pkg::LEAD_RESET;
         cfg_ff.hold_ticks <= hrs_pkg::HOLD_RESET;
         cfg_ff.beep_ticks <= hrs_pkg::BEEP_RESET;
         cfg_ff.dark_ticks <= hrs_pkg::DARK_RESET;
         cfg_ff.lit_ticks  <= hrs_pkg::LIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> rtl/core/hrs_seq.sv
// ----------------------------------------------------------------------------
// hrs_seq - switching sequencer state and tick step
// Holds phase, timers, beep count, alarm and blink state and the drive
// levels; advances them by one tick whenever a request is stepped.
// ----------------------------------------------------------------------------
module hrs_seq (
   input  logic                clock,
   input  logic                reset,
   input  hrs_pkg::cfg_type    cfg,
   input  logic                step,
   input  logic                run,
   input  logic                hot,
   output hrs_pkg::drive_type  drive_next,
   output hrs_pkg::drive_type  drive
);

   hrs_pkg::phase_type              phase_ff, phase_in;
   logic [hrs_pkg::TICK_W-1:0]      timer_ff, timer_in;
   logic [hrs_pkg::BEEPS_W-1:0]     beeps_ff, beeps_in;
   logic                            heater_ff, heater_in;
   logic                            alarm_ff, alarm_in;
   logic                            dark_ff, dark_in;
   logic [hrs_pkg::TICK_W-1:0]      blink_ff, blink_in;
   hrs_pkg::drive_type              drive_ff, drive_in;

   logic [hrs_pkg::TICK_W-1:0]      limit_raw;
   logic [hrs_pkg::TICK_W-1:0]      limit;
   logic [hrs_pkg::TICK_W-1:0]      timer_inc;

   // pick the length of the running phase; zero counts as one
   always_comb begin
      unique case (phase_ff)
         hrs_pkg::PH_GAP, hrs_pkg::PH_TONE:          limit_raw = cfg.beep_ticks;
         hrs_pkg::PH_ON_LEAD, hrs_pkg::PH_OFF_LEAD:  limit_raw = cfg.lead_ticks;
         default:                                    limit_raw = cfg.hold_ticks;
      endcase
      limit     = (limit_raw == '0) ? hrs_pkg::TICK_W'(1) : limit_raw;
      timer_inc = (timer_ff == hrs_pkg::TIMER_MAX) ? timer_ff : timer_ff + 1'b1;
   end

   // one tick of the sequencer
   always_comb begin
      phase_in  = phase_ff;
      timer_in  = timer_ff;
      beeps_in  = beeps_ff;
      heater_in = heater_ff;
      alarm_in  = alarm_ff;
      dark_in   = dark_ff;
      blink_in  = blink_ff;
      drive_in  = drive_ff;

      unique case (phase_ff)
         hrs_pkg::PH_GAP, hrs_pkg::PH_TONE, hrs_pkg::PH_ON_LEAD,
         hrs_pkg::PH_OFF_LEAD, hrs_pkg::PH_HOLD: begin
            timer_in = timer_inc;
            if (timer_inc >= limit) begin
               timer_in = '0;
               unique case (phase_ff)
                  hrs_pkg::PH_GAP: begin
                     drive_in.beeper = 1'b1;
                     phase_in        = hrs_pkg::PH_TONE;
                  end
                  hrs_pkg::PH_TONE: begin
                     drive_in.beeper = 1'b0;
                     if (beeps_ff != '0) begin
                        beeps_in = beeps_ff - 1'b1;
                        phase_in = hrs_pkg::PH_GAP;
                     end else begin
                        phase_in = hrs_pkg::PH_IDLE;
                     end
                  end
                  hrs_pkg::PH_ON_LEAD: begin
                     drive_in.relay = 1'b1;
                     phase_in       = hrs_pkg::PH_HOLD;
                  end
                  hrs_pkg::PH_OFF_LEAD: begin
                     drive_in.relay = 1'b0;
                     phase_in       = hrs_pkg::PH_HOLD;
                  end
                  default: begin
                     // hold done: drop triac and beeper, settle heater state
                     drive_in.triac  = 1'b0;
                     drive_in.beeper = 1'b0;
                     heater_in       = drive_ff.relay;
                     if (beeps_ff != '0) begin
                        beeps_in     = beeps_ff - 1'b1;
                        drive_in.led = 1'b1;
                        phase_in     = hrs_pkg::PH_GAP;
                     end else begin
                        phase_in = hrs_pkg::PH_IDLE;
                     end
                  end
               endcase
            end
         end
         default: begin
            if (hot) begin
               // overheat: force off, or light the LED and sound the alarm
               if (heater_ff) begin
                  drive_in.beeper = 1'b1;
                  drive_in.triac  = 1'b1;
                  if (!alarm_ff) begin
                     alarm_in = 1'b1;
                     beeps_in = hrs_pkg::ALARM_BEEPS_ON;
                  end
                  phase_in = hrs_pkg::PH_OFF_LEAD;
                  timer_in = '0;
               end else begin
                  drive_in.led = 1'b1;
                  if (!alarm_ff) begin
                     alarm_in = 1'b1;
                     beeps_in = hrs_pkg::ALARM_BEEPS_OFF;
                     phase_in = hrs_pkg::PH_GAP;
                     timer_in = '0;
                  end
               end
            end else if (alarm_ff) begin
               // recovery: one beep
               alarm_in = 1'b0;
               beeps_in = '0;
               phase_in = hrs_pkg::PH_GAP;
               timer_in = '0;
            end else if (run && !heater_ff) begin
               heater_in       = 1'b1;
               drive_in.beeper = 1'b1;
               drive_in.triac  = 1'b1;
               drive_in.led    = 1'b0;
               phase_in        = hrs_pkg::PH_ON_LEAD;
               timer_in        = '0;
            end else if (!run && heater_ff) begin
               drive_in.beeper = 1'b1;
               drive_in.triac  = 1'b1;
               phase_in        = hrs_pkg::PH_OFF_LEAD;
               timer_in        = '0;
            end else if (!heater_ff) begin
               // standby blink: compare, then count
               if (!dark_in && blink_in == cfg.lit_ticks) begin
                  dark_in      = 1'b1;
                  blink_in     = '0;
                  drive_in.led = 1'b0;
               end
               if (dark_in && blink_in == cfg.dark_ticks) begin
                  dark_in      = 1'b0;
                  blink_in     = '0;
                  drive_in.led = 1'b1;
               end
               blink_in = blink_in + 1'b1;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= hrs_pkg::PH_GAP;
         timer_ff  <= '0;
         beeps_ff  <= '0;
         heater_ff <= 1'b0;
         alarm_ff  <= 1'b0;
         dark_ff   <= 1'b1;
         blink_ff  <= '0;
         drive_ff  <= '0;
      end else if (step) begin
         phase_ff  <= phase_in;
         timer_ff  <= timer_in;
         beeps_ff  <= beeps_in;
         heater_ff <= heater_in;
         alarm_ff  <= alarm_in;
         dark_ff   <= dark_in;
         blink_ff  <= blink_in;
         drive_ff  <= drive_in;
      end
   end

   assign drive_next = drive_in;
   assign drive      = drive_ff;

endmodule

>>> rtl/core/heater_relay_switch_sequencer_core.sv
// ----------------------------------------------------------------------------
// heater_relay_switch_sequencer_core - heater relay switch sequencer
// Sequences triac, relay, beeper and status LED from run and overheat ticks.
//
//   channel   dir  handshake      payload
//   req_if    in   valid/ready    run_switch_closed, overheat_tripped
//   rsp_if    out  valid/ready    beeper_on, status_led_on, triac_on, relay_on
//   csr_*     in   csr_wr_en      csr_index (3b), csr_wdata (16b)
//
// One request per cycle while the result is not stalled; each request's result
// passes the input register, then the result register around a one-tick step.
// Synchronous reset restores the register defaults and starts the startup
// beep; no clearing pass is needed. A stalled result holds in the result
// register while the input register keeps one more request.
// ----------------------------------------------------------------------------
module heater_relay_switch_sequencer_core (
   input  logic                           clock,
   input  logic                           reset,
   hrs_req_if.sink                        req_if,
   hrs_rsp_if.source                      rsp_if,
   input  logic                           csr_wr_en,
   input  logic [hrs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [hrs_pkg::TICK_W-1:0]     csr_wdata
);

   hrs_pkg::cfg_type    cfg;
   hrs_pkg::drive_type  drive_next;
   hrs_pkg::drive_type  drive;

   logic                in_valid_ff;
   logic                in_run_ff;
   logic                in_hot_ff;
   logic                out_valid_ff;
   hrs_pkg::drive_type  out_drive_ff;
   logic                advance;
   logic                step;

   hrs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   hrs_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .step       (step),
      .run        (in_run_ff),
      .hot        (in_hot_ff),
      .drive_next (drive_next),
      .drive      (drive)
   );

   // advance when the result register is free or being drained
   assign advance      = !out_valid_ff || rsp_if.ready;
   assign step         = in_valid_ff && advance;
   assign req_if.ready = !in_valid_ff || advance;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         in_valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.ready && req_if.valid) begin
         in_run_ff <= req_if.run_switch_closed;
         in_hot_ff <= req_if.overheat_tripped;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         out_drive_ff <= drive_next;
      end
   end

   assign rsp_if.valid         = out_valid_ff;
   assign rsp_if.beeper_on     = out_drive_ff.beeper;
   assign rsp_if.status_led_on = out_drive_ff.led;
   assign rsp_if.triac_on      = out_drive_ff.triac;
   assign rsp_if.relay_on      = out_drive_ff.relay;

   // a stepped request always lands in the result register
   a_step_lands: assert property (@(posedge clock) disable iff (reset)
      step |=> out_valid_ff)
      else $error("stepped request did not reach the result register");

   // the triac never conducts with the beeper silent
   a_triac_beeps: assert property (@(posedge clock) disable iff (reset)
      drive.triac |-> drive.beeper)
      else $error("triac on without beeper");

   // the relay only changes while the triac carries the load
   a_relay_under_triac: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$stable(drive.relay)) |-> (drive.triac && $past(drive.triac)))
      else $error("relay switched without triac");

endmodule
